[rtl/sham_pkg.sv]
// ----------------------------------------------------------------------------
// sham_pkg
// Shared types and constants for the stepper axis home-and-move block.
// ----------------------------------------------------------------------------
package sham_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned STEPS_W  = 16;
  localparam int unsigned PULSE_W  = 20;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [PERIOD_W-1:0] MOVE_PERIOD_RST    = 16'd15;
  localparam logic [PERIOD_W-1:0] HOME_PERIOD_RST    = 16'd15;
  localparam logic [PERIOD_W-1:0] BACKOFF_PERIOD_RST = 16'd1;
  localparam logic [STEPS_W-1:0]  BACKOFF_STEPS_RST  = 16'd200;
  localparam logic [PULSE_W-1:0]  STALL_LIMIT_RST    = 20'd500000;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_MOVE = 2'd1,
    KIND_HOME = 2'd2,
    KIND_RSVD = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_MOVE = 2'd1,
    PH_SEEK = 2'd2,
    PH_BACK = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOVE_PERIOD    = 3'd0,
    REG_HOME_PERIOD    = 3'd1,
    REG_BACKOFF_PERIOD = 3'd2,
    REG_BACKOFF_STEPS  = 3'd3,
    REG_BACKOFF_REV    = 3'd4,
    REG_STALL_LIMIT    = 3'd5,
    REG_KEEP_ENABLED   = 3'd6,
    REG_SWITCH_LEVEL   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] move_period;
    logic [PERIOD_W-1:0] home_period;
    logic [PERIOD_W-1:0] backoff_period;
    logic [STEPS_W-1:0]  backoff_steps;
    logic                backoff_reverse;
    logic [PULSE_W-1:0]  stall_limit;
    logic                keep_enabled;
    logic                switch_active_level;
  } sham_cfg_t;

  // Fields listed from the highest bit down; step_toggle sits in bit 0.
  typedef struct packed {
    logic             cmd_rejected;
    logic             stalled;
    logic [POS_W-1:0] position;
    logic             busy_res;
    logic             drive_enable;
    logic             direction;
    logic             step_toggle;
  } sham_res_t;

endpackage

[rtl/sham_cfg.sv]
// ----------------------------------------------------------------------------
// sham_cfg
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module sham_cfg
  import sham_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PULSE_W-1:0]   cfg_data,
  output sham_cfg_t            cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.move_period         <= MOVE_PERIOD_RST;
      cfg.home_period         <= HOME_PERIOD_RST;
      cfg.backoff_period      <= BACKOFF_PERIOD_RST;
      cfg.backoff_steps       <= BACKOFF_STEPS_RST;
      cfg.backoff_reverse     <= 1'b1;
      cfg.stall_limit         <= STALL_LIMIT_RST;
      cfg.keep_enabled        <= 1'b0;
      cfg.switch_active_level <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MOVE_PERIOD:    cfg.move_period         <= cfg_data[PERIOD_W-1:0];
        REG_HOME_PERIOD:    cfg.home_period         <= cfg_data[PERIOD_W-1:0];
        REG_BACKOFF_PERIOD: cfg.backoff_period      <= cfg_data[PERIOD_W-1:0];
        REG_BACKOFF_STEPS:  cfg.backoff_steps       <= cfg_data[STEPS_W-1:0];
        REG_BACKOFF_REV:    cfg.backoff_reverse     <= cfg_data[0];
        REG_STALL_LIMIT:    cfg.stall_limit         <= cfg_data;
        REG_KEEP_ENABLED:   cfg.keep_enabled        <= cfg_data[0];
        REG_SWITCH_LEVEL:   cfg.switch_active_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/sham_core.sv]
// ----------------------------------------------------------------------------
// sham_core
// Axis state and the single-pass update for one accepted item.
// ----------------------------------------------------------------------------
module sham_core
  import sham_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned TICK_BITS     = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [1:0]       kind_in,
  input  logic [POS_W-1:0] target,
  input  logic             home_dir,
  input  logic             switch_level,
  input  sham_cfg_t        cfg,
  output sham_res_t        res
);

  localparam int unsigned CMP_W = (TICK_BITS > PERIOD_W) ? TICK_BITS : PERIOD_W;

  phase_t                   phase, phase_next;
  logic [POSITION_BITS-1:0] axis_position, axis_position_next;
  logic [POSITION_BITS-1:0] steps_left, steps_left_next;
  logic [POSITION_BITS-1:0] pending_target, pending_target_next;
  logic [TICK_BITS-1:0]     tick_count, tick_count_next;
  logic [PULSE_W-1:0]       seek_pulses, seek_pulses_next;
  logic                     dir_level, dir_level_next;
  logic                     enable_level, enable_level_next;
  logic                     stall_flag, stall_flag_next;

  kind_t                    kind;
  logic                     is_cmd;
  logic [PERIOD_W-1:0]      period_sel;
  logic [TICK_BITS-1:0]     tick_inc;
  logic                     due;
  logic                     sw_hit;
  logic [POSITION_BITS-1:0] steps_dec;
  logic [POSITION_BITS-1:0] tgt;
  logic [POSITION_BITS-1:0] bo_steps;
  logic                     at_target;
  logic [PULSE_W-1:0]       pulses_inc;
  logic                     toggle;
  logic                     rejected;

  assign kind       = kind_t'(kind_in);
  assign is_cmd     = (kind == KIND_MOVE) || (kind == KIND_HOME);
  assign tick_inc   = tick_count + 1'b1;
  assign sw_hit     = (switch_level == cfg.switch_active_level);
  assign steps_dec  = steps_left - 1'b1;
  assign tgt        = POSITION_BITS'(target);
  assign bo_steps   = POSITION_BITS'(cfg.backoff_steps);
  assign at_target  = (tgt == axis_position);
  assign pulses_inc = seek_pulses + 1'b1;

  always_comb begin
    case (phase)
      PH_MOVE: period_sel = cfg.move_period;
      PH_SEEK: period_sel = cfg.home_period;
      default: period_sel = cfg.backoff_period;
    endcase
  end

  assign due = (CMP_W'(tick_inc) >= CMP_W'(period_sel)) || (tick_inc == '0);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (kind == KIND_MOVE && !at_target) begin
          phase_next = PH_MOVE;
        end else if (kind == KIND_HOME) begin
          phase_next = PH_SEEK;
        end
      end
      PH_MOVE, PH_BACK: begin
        if (!is_cmd && due && steps_dec == '0) begin
          phase_next = PH_IDLE;
        end
      end
      PH_SEEK: begin
        if (!is_cmd && sw_hit) begin
          phase_next = (bo_steps == '0) ? PH_IDLE : PH_BACK;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    axis_position_next  = axis_position;
    steps_left_next     = steps_left;
    pending_target_next = pending_target;
    tick_count_next     = tick_count;
    seek_pulses_next    = seek_pulses;
    dir_level_next      = dir_level;
    enable_level_next   = enable_level;
    stall_flag_next     = stall_flag;
    toggle              = 1'b0;
    rejected            = 1'b0;
    if (is_cmd) begin
      if (phase != PH_IDLE) begin
        rejected = 1'b1;
      end else if (kind == KIND_MOVE) begin
        if (at_target) begin
          enable_level_next = cfg.keep_enabled;
        end else begin
          if (tgt > axis_position) begin
            steps_left_next = tgt - axis_position;
            dir_level_next  = 1'b1;
          end else begin
            steps_left_next = axis_position - tgt;
            dir_level_next  = 1'b0;
          end
          pending_target_next = tgt;
          enable_level_next   = 1'b1;
          tick_count_next     = '0;
        end
      end else begin
        dir_level_next    = home_dir;
        enable_level_next = 1'b1;
        tick_count_next   = '0;
        seek_pulses_next  = '0;
        stall_flag_next   = 1'b0;
      end
    end else begin
      case (phase)
        PH_MOVE, PH_BACK: begin
          tick_count_next = due ? '0 : tick_inc;
          if (due) begin
            toggle          = 1'b1;
            steps_left_next = steps_dec;
            if (steps_dec == '0) begin
              axis_position_next = (phase == PH_MOVE) ? pending_target : '0;
              enable_level_next  = cfg.keep_enabled;
            end
          end
        end
        PH_SEEK: begin
          if (sw_hit) begin
            dir_level_next  = dir_level ^ cfg.backoff_reverse;
            steps_left_next = bo_steps;
            tick_count_next = '0;
            if (bo_steps == '0) begin
              axis_position_next = '0;
              enable_level_next  = cfg.keep_enabled;
            end
          end else begin
            tick_count_next = due ? '0 : tick_inc;
            if (due) begin
              toggle = 1'b1;
              if (seek_pulses != '1) begin
                seek_pulses_next = pulses_inc;
                if (pulses_inc == cfg.stall_limit) begin
                  enable_level_next = 1'b0;
                  stall_flag_next   = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      axis_position  <= '0;
      steps_left     <= '0;
      pending_target <= '0;
      tick_count     <= '0;
      seek_pulses    <= '0;
      dir_level      <= 1'b0;
      enable_level   <= 1'b0;
      stall_flag     <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      axis_position  <= axis_position_next;
      steps_left     <= steps_left_next;
      pending_target <= pending_target_next;
      tick_count     <= tick_count_next;
      seek_pulses    <= seek_pulses_next;
      dir_level      <= dir_level_next;
      enable_level   <= enable_level_next;
      stall_flag     <= stall_flag_next;
    end
  end

  always_comb begin
    res.step_toggle  = toggle;
    res.direction    = dir_level_next;
    res.drive_enable = enable_level_next;
    res.busy_res     = (phase_next != PH_IDLE);
    res.position     = POS_W'(axis_position_next);
    res.stalled      = stall_flag_next;
    res.cmd_rejected = rejected;
  end

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    accept && rejected |=> phase == $past(phase) && axis_position == $past(axis_position))
    else $error("rejected command changed the axis state");

  a_idle_no_step: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_IDLE && !is_cmd |-> !toggle && phase_next == PH_IDLE)
    else $error("idle axis stepped or started on a tick");

  a_stall_in_seek: assert property (@(posedge clk) disable iff (rst)
    accept && stall_flag_next && !stall_flag |-> phase == PH_SEEK)
    else $error("stall flag raised outside the seek phase");

  a_cmd_clears_tick: assert property (@(posedge clk) disable iff (rst)
    accept && is_cmd && phase == PH_IDLE && phase_next != PH_IDLE |=> tick_count == '0)
    else $error("started command did not clear the tick counter");

endmodule

[rtl/sham_obuf.sv]
// ----------------------------------------------------------------------------
// sham_obuf
// Two-entry result buffer between the core and the output stream.
// ----------------------------------------------------------------------------
module sham_obuf
  import sham_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  sham_res_t wr_data,
  output logic      not_full,
  output logic      m_tvalid,
  input  logic      m_tready,
  output sham_res_t rd_data
);

  sham_res_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       rd_en;

  assign not_full = (count != 2'd2);
  assign m_tvalid = (count != 2'd0);
  assign rd_en    = m_tvalid && m_tready;
  assign rd_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

endmodule

[rtl/stepper_axis_home_and_move_top.sv]
// ----------------------------------------------------------------------------
// stepper_axis_home_and_move_top
// Step/direction generator for one stepper axis with moves and homing.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tick, move or home item; tuser = kind
// m_axis    out        one result per accepted item
// cfg       in         register index and write data
//
// One item is accepted per cycle while s_tready is high; its result, set by
// the single state update in the core, is registered and appears on m_tdata.
// A two-entry result buffer keeps input flowing while the output stalls;
// s_tready drops only when both entries hold untaken results.
// Reset is synchronous; all axis state and configuration return to defaults.
// ----------------------------------------------------------------------------
module stepper_axis_home_and_move_top
  import sham_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned TICK_BITS     = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // target[15:0], home_dir[16], switch_level[17], zero[23:18]
  input  logic [23:0]          s_tdata,
  // kind[1:0]
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // step_toggle[0], direction[1], drive_enable[2], busy_res[3],
  // position[19:4], stalled[20], cmd_rejected[21], zero[23:22]
  output logic [23:0]          m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PULSE_W-1:0]   cfg_data
);

  sham_cfg_t cfg;
  sham_res_t core_res;
  sham_res_t out_res;
  logic      accept;

  assign accept = s_tvalid && s_tready;

  sham_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sham_core #(
    .POSITION_BITS (POSITION_BITS),
    .TICK_BITS     (TICK_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .kind_in      (s_tuser),
    .target       (s_tdata[POS_W-1:0]),
    .home_dir     (s_tdata[POS_W]),
    .switch_level (s_tdata[POS_W+1]),
    .cfg          (cfg),
    .res          (core_res)
  );

  sham_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_data  (core_res),
    .not_full (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .rd_data  (out_res)
  );

  assign m_tdata = {(24 - $bits(sham_res_t))'(0), out_res};

endmodule

[test/tb_stepper_axis_home_and_move_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_axis_home_and_move_top
// Self-checking bench for the stepper axis step/direction generator. Ticks,
// moves and homing commands are streamed in with random gaps while the
// result stream is stalled at random. A scoreboard predicts every result
// from its own copy of the axis state and configuration and compares each
// transfer field by field. Register settings change between phases while
// the axis is idle, including zero, maximum and very long periods.
// ----------------------------------------------------------------------------
module tb_stepper_axis_home_and_move_top
  import sham_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  class axis_scoreboard;
    sham_cfg_t          cfg;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   goal;
    logic [POS_W-1:0]   steps_left;
    logic [15:0]        tick_cnt;
    logic [PULSE_W-1:0] seek_pulses;
    phase_t             ph;
    logic               dir;
    logic               en;
    logic               stall;
    sham_res_t          pending_results[$];
    int unsigned        errors;

    function new();
      cfg.move_period         = MOVE_PERIOD_RST;
      cfg.home_period         = HOME_PERIOD_RST;
      cfg.backoff_period      = BACKOFF_PERIOD_RST;
      cfg.backoff_steps       = BACKOFF_STEPS_RST;
      cfg.backoff_reverse     = 1'b1;
      cfg.stall_limit         = STALL_LIMIT_RST;
      cfg.keep_enabled        = 1'b0;
      cfg.switch_active_level = 1'b0;
      pos         = '0;
      goal        = '0;
      steps_left  = '0;
      tick_cnt    = '0;
      seek_pulses = '0;
      ph          = PH_IDLE;
      dir         = 1'b0;
      en          = 1'b0;
      stall       = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [PULSE_W-1:0] v);
      case (idx)
        REG_MOVE_PERIOD:    cfg.move_period         = v[15:0];
        REG_HOME_PERIOD:    cfg.home_period         = v[15:0];
        REG_BACKOFF_PERIOD: cfg.backoff_period      = v[15:0];
        REG_BACKOFF_STEPS:  cfg.backoff_steps       = v[15:0];
        REG_BACKOFF_REV:    cfg.backoff_reverse     = v[0];
        REG_STALL_LIMIT:    cfg.stall_limit         = v;
        REG_KEEP_ENABLED:   cfg.keep_enabled        = v[0];
        REG_SWITCH_LEVEL:   cfg.switch_active_level = v[0];
        default: ;
      endcase
    endfunction

    // A period of zero behaves as one, since the next count is always >= 0.
    function bit tick_due(logic [15:0] period);
      logic [15:0] nxt;
      nxt = tick_cnt + 16'd1;
      if (nxt >= period || nxt == 16'd0) begin
        tick_cnt = '0;
        return 1'b1;
      end
      tick_cnt = nxt;
      return 1'b0;
    endfunction

    function void complete();
      ph = PH_IDLE;
      en = cfg.keep_enabled;
    endfunction

    function void predict_item(kind_t kind, logic [POS_W-1:0] target, logic hdir, logic sw);
      sham_res_t r;
      r = '0;
      if (kind == KIND_MOVE || kind == KIND_HOME) begin
        if (ph != PH_IDLE) begin
          r.cmd_rejected = 1'b1;
        end else if (kind == KIND_MOVE) begin
          if (target == pos) begin
            complete();
          end else begin
            dir        = target > pos;
            steps_left = dir ? target - pos : pos - target;
            goal       = target;
            en         = 1'b1;
            tick_cnt   = '0;
            ph         = PH_MOVE;
          end
        end else begin
          dir         = hdir;
          en          = 1'b1;
          tick_cnt    = '0;
          seek_pulses = '0;
          stall       = 1'b0;
          ph          = PH_SEEK;
        end
      end else begin
        case (ph)
          PH_MOVE: begin
            if (tick_due(cfg.move_period)) begin
              r.step_toggle = 1'b1;
              steps_left = steps_left - 1'b1;
              if (steps_left == '0) begin
                pos = goal;
                complete();
              end
            end
          end
          PH_SEEK: begin
            if (sw == cfg.switch_active_level) begin
              if (cfg.backoff_reverse) dir = ~dir;
              steps_left = cfg.backoff_steps;
              tick_cnt   = '0;
              if (steps_left == '0) begin
                pos = '0;
                complete();
              end else begin
                ph = PH_BACK;
              end
            end else if (tick_due(cfg.home_period)) begin
              r.step_toggle = 1'b1;
              if (seek_pulses != {PULSE_W{1'b1}}) begin
                seek_pulses = seek_pulses + 1'b1;
                if (seek_pulses == cfg.stall_limit) begin
                  en    = 1'b0;
                  stall = 1'b1;
                end
              end
            end
          end
          PH_BACK: begin
            if (tick_due(cfg.backoff_period)) begin
              r.step_toggle = 1'b1;
              steps_left = steps_left - 1'b1;
              if (steps_left == '0) begin
                pos = '0;
                complete();
              end
            end
          end
          default: ;
        endcase
      end
      r.direction    = dir;
      r.drive_enable = en;
      r.busy_res     = ph != PH_IDLE;
      r.position     = pos;
      r.stalled      = stall;
      pending_results.push_back(r);
    endfunction

    function void compare(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(logic [23:0] data);
      sham_res_t act;
      sham_res_t exp;
      act = data[21:0];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, data);
      end else begin
        exp = pending_results.pop_front();
        compare("step_toggle", 32'(exp.step_toggle), 32'(act.step_toggle));
        compare("direction", 32'(exp.direction), 32'(act.direction));
        compare("drive_enable", 32'(exp.drive_enable), 32'(act.drive_enable));
        compare("busy_res", 32'(exp.busy_res), 32'(act.busy_res));
        compare("position", 32'(exp.position), 32'(act.position));
        compare("stalled", 32'(exp.stalled), 32'(act.stalled));
        compare("cmd_rejected", 32'(exp.cmd_rejected), 32'(act.cmd_rejected));
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata = '0;
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [23:0]          m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PULSE_W-1:0]   cfg_data = '0;

  axis_scoreboard sb = new();
  int unsigned    items_sent = 0;
  int unsigned    cycle_count = 0;
  bit             calm = 1'b0;
  bit             choke_req = 1'b0;

  stepper_axis_home_and_move_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result sink: random stalls, one long hold-off on request, none when calm.
  initial begin : sink
    while (rst) @(posedge clk);
    forever begin
      if (choke_req) begin
        choke_req = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  task automatic send(kind_t kind, logic [15:0] target, logic hdir, logic sw);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {6'd0, sw, hdir, target};
    do @(posedge clk); while (!s_tready);
    sb.predict_item(kind, target, hdir, sw);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Bits above the register width carry junk; the block must ignore them.
  task automatic program_reg(cfg_reg_t idx, logic [PULSE_W-1:0] value);
    logic [PULSE_W-1:0] junk;
    junk = PULSE_W'($urandom);
    case (idx)
      REG_STALL_LIMIT: ;
      REG_BACKOFF_REV, REG_KEEP_ENABLED, REG_SWITCH_LEVEL:
        value = {junk[PULSE_W-1:1], value[0]};
      default: value = {junk[PULSE_W-1:16], value[15:0]};
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic busy_tick(logic sw);
    int unsigned pick;
    pick = $urandom_range(0, 11);
    if (pick == 0)
      send($urandom_range(0, 1) ? KIND_MOVE : KIND_HOME, 16'($urandom),
           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else
      send(pick == 1 ? KIND_RSVD : KIND_TICK, 16'($urandom), 1'($urandom_range(0, 1)), sw);
  endtask

  task automatic run_to_idle();
    while (sb.ph != PH_IDLE) busy_tick(1'($urandom_range(0, 1)));
  endtask

  task automatic setup_phase(bit slow);
    logic [PULSE_W-1:0] pick;
    drain();
    program_reg(REG_MOVE_PERIOD, slow ? 20'hFFFF : PULSE_W'($urandom_range(0, 3)));
    program_reg(REG_HOME_PERIOD, slow ? 20'hFFFF : PULSE_W'($urandom_range(0, 3)));
    program_reg(REG_BACKOFF_PERIOD, slow ? 20'hFFFF : PULSE_W'($urandom_range(0, 2)));
    pick = ($urandom_range(0, 3) == 0) ? '0 : PULSE_W'($urandom_range(1, 8));
    program_reg(REG_BACKOFF_STEPS, slow ? '0 : pick);
    program_reg(REG_BACKOFF_REV, PULSE_W'($urandom_range(0, 1)));
    case ($urandom_range(0, 3))
      0: pick = '0;
      1: pick = PULSE_W'(1);
      2: pick = PULSE_W'($urandom_range(2, 30));
      default: pick = '1;
    endcase
    program_reg(REG_STALL_LIMIT, pick);
    program_reg(REG_KEEP_ENABLED, PULSE_W'($urandom_range(0, 1)));
    program_reg(REG_SWITCH_LEVEL, PULSE_W'($urandom_range(0, 1)));
  endtask

  task automatic run_sequences(int unsigned budget);
    int unsigned start;
    int          t;
    logic        lvl;
    start = items_sent;
    while (items_sent - start < budget) begin
      lvl = sb.cfg.switch_active_level;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          t = int'(sb.pos) + int'($urandom_range(0, 24)) - 12;
          if (t < 0) t = 0;
          if (t > 65535) t = 65535;
          if (sb.cfg.move_period > 16) t = int'(sb.pos);
          send(KIND_MOVE, 16'(t), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          run_to_idle();
        end
        4, 5, 6: begin
          send(KIND_HOME, 16'($urandom), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
          repeat ($urandom_range(0, 40)) busy_tick(~lvl);
          send($urandom_range(0, 1) ? KIND_RSVD : KIND_TICK, 16'($urandom),
               1'($urandom_range(0, 1)), lvl);
          run_to_idle();
        end
        default: begin
          repeat ($urandom_range(1, 4))
            send($urandom_range(0, 1) ? KIND_RSVD : KIND_TICK, 16'($urandom),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      endcase
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    program_reg(REG_MOVE_PERIOD, 20'd2);
    program_reg(REG_HOME_PERIOD, 20'd1);
    program_reg(REG_BACKOFF_PERIOD, 20'd0);
    program_reg(REG_BACKOFF_STEPS, 20'd3);
    program_reg(REG_BACKOFF_REV, 20'd1);
    program_reg(REG_STALL_LIMIT, 20'd2);
    program_reg(REG_KEEP_ENABLED, 20'd0);
    program_reg(REG_SWITCH_LEVEL, 20'd1);

    send(KIND_TICK, 16'hFFFF, 1'b1, 1'b1);
    send(KIND_RSVD, 16'h0000, 1'b0, 1'b0);
    send(KIND_MOVE, 16'h0000, 1'b1, 1'b1);
    send(KIND_MOVE, 16'd3, 1'b0, 1'b0);
    send(KIND_MOVE, 16'hFFFF, 1'b1, 1'b1);
    send(KIND_HOME, 16'h0000, 1'b1, 1'b0);
    repeat (3) begin
      send(KIND_TICK, 16'h0000, 1'b0, 1'b1);
      send(KIND_RSVD, 16'hFFFF, 1'b1, 1'b0);
    end
    send(KIND_MOVE, 16'd1, 1'b1, 1'b0);
    repeat (4) send(KIND_TICK, 16'h0000, 1'b0, 1'b0);
    // Seek past the stall limit, then see the switch and back off.
    send(KIND_HOME, 16'h0000, 1'b1, 1'b0);
    repeat (3) send(KIND_TICK, 16'h0000, 1'b0, 1'b0);
    send(KIND_TICK, 16'h0000, 1'b0, 1'b1);
    repeat (3) send(KIND_TICK, 16'h0000, 1'b0, 1'b0);
    drain();
    program_reg(REG_BACKOFF_STEPS, 20'd0);
    send(KIND_HOME, 16'h0000, 1'b0, 1'b0);
    send(KIND_TICK, 16'h0000, 1'b0, 1'b1);

    for (int p = 0; p < 10; p++) begin
      setup_phase(p == 3);
      if (p == 2) choke_req = 1'b1;
      if (p >= 8) calm = 1'b1;
      run_sequences(100);
    end

    // Longer move and back-off, with no idling on either side.
    drain();
    program_reg(REG_BACKOFF_STEPS, 20'd0);
    program_reg(REG_MOVE_PERIOD, 20'd1);
    send(KIND_HOME, 16'h0000, 1'b0, 1'b0);
    send(KIND_TICK, 16'h0000, 1'b0, sb.cfg.switch_active_level);
    send(KIND_MOVE, 16'd64, 1'b1, 1'b1);
    run_to_idle();
    drain();
    program_reg(REG_BACKOFF_STEPS, 20'd48);
    program_reg(REG_BACKOFF_PERIOD, 20'd1);
    program_reg(REG_STALL_LIMIT, 20'd0);
    send(KIND_HOME, 16'hFFFF, 1'b1, 1'b1);
    repeat (5) busy_tick(~sb.cfg.switch_active_level);
    send(KIND_TICK, 16'h0000, 1'b0, sb.cfg.switch_active_level);
    run_to_idle();

    drain();
    repeat (12) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
